### rtl/core/fca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fca_pkg;

    // stream widths
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // serial divider
    localparam int DIV_CNT_W      = 6;
    localparam int DIV_FULL_STEPS = 34;  // diff*mass / total mass

    // ceil(2^17 / 3); x * SKEW_RECIP >> 17 == x / 3 for any 16-bit x
    localparam logic [16:0] SKEW_RECIP = 17'd43691;

    typedef logic signed [15:0] point_t;
    typedef logic        [16:0] strength_t;
    typedef logic        [31:0] mass_t;
    typedef logic signed [16:0] acc_value_t;

endpackage

`default_nettype wire

### rtl/core/fuzzy_centroid_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// An ordered term runs order check, mass and skew products, skew quotient, centroid and diff,
// diff*mass product, the 34-step run of the restoring divider, update and hand-off; a zero
// total mass skips the divide and update, and a rejected term goes from check to hand-off.
// A new term is taken only after the last one is handed off; s_tready is high only between terms.
// A stalled result beat holds the sequencer in the hand-off step until the output frees.
// Reset (rst_n low, asynchronous): accumulated value and mass go to zero, no result pending.
module fuzzy_centroid_accumulator
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // [15:0] left_point, [31:16] peak_point, [47:32] right_point,
    // [64:48] strength, [71:65] zero
    input  wire  [fca_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] first_term
    input  wire  [fca_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // [15:0] centroid, [47:16] total_mass
    output logic [fca_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] term_rejected
    output logic [fca_pkg::M_TUSER_W-1:0] m_tuser
);
    import fca_pkg::*;

    // Sequencer. One 18x18 signed multiplier is shared by the mass, skew,
    // skew quotient and diff*mass steps of a term, beside one restoring
    // divider (one quotient bit per cycle). The divide by 3 of the skew
    // term goes through the multiplier as a reciprocal product.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CHECK   = 4'd1;   // order check, first-term clear
    localparam logic [3:0] S_MASS    = 4'd2;   // prod = strength * base
    localparam logic [3:0] S_SKEW    = 4'd3;   // mass = prod >> 17; prod = strength * skew
    localparam logic [3:0] S_SKEW_Q  = 4'd4;   // skew quotient = ((|prod| >> 17) * recip) >> 17
    localparam logic [3:0] S_DIFF    = 4'd6;   // centroid, diff, mass total
    localparam logic [3:0] S_PROD    = 4'd7;   // prod = diff * mass
    localparam logic [3:0] S_DIVB_LD = 4'd8;   // load |prod| / total mass
    localparam logic [3:0] S_DIVB    = 4'd9;
    localparam logic [3:0] S_UPD     = 4'd10;  // fold quotient into value, saturate
    localparam logic [3:0] S_OUT     = 4'd11;  // hand result to output register

    // control state
    logic [3:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    acc_value_t           acc_value_reg, acc_value_next;
    mass_t                acc_mass_reg, acc_mass_next;

    // payload
    logic                 first_reg, first_next;
    point_t               left_reg, left_next;
    point_t               peak_reg, peak_next;
    point_t               right_reg, right_next;
    strength_t            str_reg, str_next;
    logic signed [35:0]   prod_reg, prod_next;
    logic [15:0]          mass_reg, mass_next;
    logic signed [17:0]   diff_reg, diff_next;
    logic                 neg_reg, neg_next;
    logic [31:0]          rem_reg, rem_next;
    logic [33:0]          quo_reg, quo_next;
    logic [31:0]          dvs_reg, dvs_next;
    logic                 rej_reg, rej_next;
    logic [15:0]          out_cen_reg, out_cen_next;
    mass_t                out_mass_reg, out_mass_next;
    logic                 out_rej_reg, out_rej_next;

    // datapath
    logic                 rejected_w;
    logic [16:0]          base_full_w;
    logic [15:0]          base_w;
    logic signed [17:0]   skew_w;
    logic signed [16:0]   sum_w;
    logic signed [16:0]   half_w;
    logic signed [17:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [35:0]   mul_p;
    logic [35:0]          prod_mag;
    logic [32:0]          part_w;
    logic [33:0]          trial_w;
    logic                 ge_w;
    logic signed [18:0]   qa_w;
    logic signed [18:0]   cen_w;
    logic signed [18:0]   diff_w;
    logic [31:0]          mass_sum_w;
    logic signed [35:0]   qb_w;
    logic signed [35:0]   upd_w;
    logic [15:0]          cen_sat_w;
    logic                 out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_mass_reg, out_cen_reg};
    assign m_tuser  = out_rej_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // triangle geometry
    assign rejected_w  = (left_reg > peak_reg) || (peak_reg > right_reg);
    assign base_full_w = 17'({right_reg[15], right_reg} - {left_reg[15], left_reg});
    assign base_w      = base_full_w[15:0];
    assign skew_w      = 18'({peak_reg[15], peak_reg, 1'b0} - {{2{right_reg[15]}}, right_reg}
                             - {{2{left_reg[15]}}, left_reg});
    assign sum_w       = 17'({left_reg[15], left_reg} + {right_reg[15], right_reg});
    // (left + right) / 2 rounded toward zero
    assign half_w      = (sum_w + $signed({16'd0, sum_w[16]})) >>> 1;

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            S_MASS:
            begin
                mul_a = {1'b0, str_reg};
                mul_b = {2'b00, base_w};
            end
            S_SKEW:
            begin
                mul_a = {1'b0, str_reg};
                mul_b = skew_w;
            end
            S_SKEW_Q:
            begin
                mul_a = {2'b00, prod_mag[32:17]};
                mul_b = {1'b0, SKEW_RECIP};
            end
            S_PROD:
            begin
                mul_a = diff_reg;
                mul_b = {2'b00, mass_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_mag = prod_reg[35] ? 36'(-prod_reg) : 36'(prod_reg);

    // one restoring divide step
    assign part_w  = {rem_reg, quo_reg[33]};
    assign trial_w = {1'b0, part_w} - {2'b00, dvs_reg};
    assign ge_w    = !trial_w[33];

    // term centroid and its distance from the running value
    assign qa_w       = neg_reg ? -{3'd0, quo_reg[15:0]} : {3'd0, quo_reg[15:0]};
    assign cen_w      = {{2{half_w[16]}}, half_w} + qa_w;
    assign diff_w     = cen_w - {{2{acc_value_reg[16]}}, acc_value_reg};
    assign mass_sum_w = acc_mass_reg + {16'd0, mass_reg};

    // mass-weighted update
    assign qb_w  = neg_reg ? -{2'b00, quo_reg} : {2'b00, quo_reg};
    assign upd_w = {{19{acc_value_reg[16]}}, acc_value_reg} + qb_w;

    always_comb
    begin
        if (acc_value_reg > 17'sd32767)
            cen_sat_w = 16'h7FFF;
        else if (acc_value_reg < -17'sd32768)
            cen_sat_w = 16'h8000;
        else
            cen_sat_w = acc_value_reg[15:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        acc_value_next = acc_value_reg;
        acc_mass_next  = acc_mass_reg;
        first_next     = first_reg;
        left_next      = left_reg;
        peak_next      = peak_reg;
        right_next     = right_reg;
        str_next       = str_reg;
        prod_next      = prod_reg;
        mass_next      = mass_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        rej_next       = rej_reg;
        out_cen_next   = out_cen_reg;
        out_mass_next  = out_mass_reg;
        out_rej_next   = out_rej_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    first_next = s_tuser[0];
                    left_next  = s_tdata[15:0];
                    peak_next  = s_tdata[31:16];
                    right_next = s_tdata[47:32];
                    str_next   = s_tdata[64:48];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                rej_next = rejected_w;
                if (rejected_w)
                    state_next = S_OUT;
                else
                begin
                    if (first_reg)
                    begin
                        acc_value_next = '0;
                        acc_mass_next  = '0;
                    end
                    state_next = S_MASS;
                end
            end
            S_MASS:
            begin
                prod_next  = mul_p;
                state_next = S_SKEW;
            end
            S_SKEW:
            begin
                // strength * base is non-negative and below 2^33
                mass_next  = prod_reg[32:17];
                prod_next  = mul_p;
                state_next = S_SKEW_Q;
            end
            S_SKEW_Q:
            begin
                // floor(|p| / (3 << 17)) == floor((|p| >> 17) / 3); quotient lands in quo[15:0]
                neg_next   = prod_reg[35];
                quo_next   = {18'd0, mul_p[32:17]};
                state_next = S_DIFF;
            end
            S_DIVB:
            begin
                rem_next = ge_w ? trial_w[31:0] : part_w[31:0];
                quo_next = {quo_reg[32:0], ge_w};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                    state_next = S_UPD;
            end
            S_DIFF:
            begin
                diff_next     = diff_w[17:0];
                acc_mass_next = mass_sum_w;
                state_next    = S_PROD;
            end
            S_PROD:
            begin
                prod_next  = mul_p;
                state_next = S_DIVB_LD;
            end
            S_DIVB_LD:
            begin
                if (acc_mass_reg == '0)
                    state_next = S_OUT;
                else
                begin
                    neg_next   = prod_reg[35];
                    rem_next   = '0;
                    quo_next   = prod_mag[33:0];
                    dvs_next   = acc_mass_reg;
                    cnt_next   = DIV_CNT_W'(DIV_FULL_STEPS);
                    state_next = S_DIVB;
                end
            end
            S_UPD:
            begin
                if (upd_w > 36'sd65535)
                    acc_value_next = 17'sd65535;
                else if (upd_w < -36'sd65536)
                    acc_value_next = -17'sd65536;
                else
                    acc_value_next = upd_w[16:0];
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_cen_next  = cen_sat_w;
                    out_mass_next = acc_mass_reg;
                    out_rej_next  = rej_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
            acc_value_reg <= '0;
            acc_mass_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            acc_value_reg <= acc_value_next;
            acc_mass_reg  <= acc_mass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg    <= first_next;
        left_reg     <= left_next;
        peak_reg     <= peak_next;
        right_reg    <= right_next;
        str_reg      <= str_next;
        prod_reg     <= prod_next;
        mass_reg     <= mass_next;
        diff_reg     <= diff_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dvs_reg      <= dvs_next;
        rej_reg      <= rej_next;
        out_cen_reg  <= out_cen_next;
        out_mass_reg <= out_mass_next;
        out_rej_reg  <= out_rej_next;
    end

    // a taken beat closes the input until the term is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after an accepted beat");

    // a result beat only appears from the output hand-off step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside hand-off");

    // divider never runs with an empty step count
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVB) |-> cnt_reg != '0)
        else $error("divider running with zero count");

    // a rejected term leaves the accumulator alone
    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK && rejected_w
        |=> $stable(acc_mass_reg) && $stable(acc_value_reg) && state_reg == S_OUT)
        else $error("rejected term changed the accumulator");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import fca_pkg::*;

    // Cycles with no beat on either side before the run is declared hung.
    // The worst correct stretch is a long sender gap plus the term latency plus
    // a long receiver stall, which stays well below the limit.
    localparam int HANG_LIMIT   = 2000;
    // Quiet cycles after the last result.
    localparam int TAIL_CYCLES  = 70;
    localparam int IDLE_PERCENT = 28;

    localparam longint MASS_DIVISOR = 64'sh20000;
    localparam longint SKEW_DIVISOR = 64'sh60000;
    localparam longint VALUE_MAX    = 65535;
    localparam longint VALUE_MIN    = -65536;
    localparam longint CENTROID_MAX = 32767;
    localparam longint CENTROID_MIN = -32768;

    typedef struct {
        point_t centroid;
        mass_t  total_mass;
        logic   rejected;
    } centroid_beat_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // [15:0] left_point, [31:16] peak_point, [47:32] right_point,
    // [64:48] strength, [71:65] zero
    logic [S_TDATA_W-1:0] s_tdata;
    // [0] first_term
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [15:0] centroid, [47:16] total_mass
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] term_rejected
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow of the accumulator state inside the block
    acc_value_t     shadow_value;
    mass_t          shadow_mass;

    // Results owed by the block, oldest first
    centroid_beat_t pending_centroids[$];
    centroid_beat_t owed;

    int  fail_count;
    int  quiet_cycles;
    int  stall_left;
    // Random idling on both sides; cleared for the back-to-back stretch
    bit  idle_on;

    fuzzy_centroid_accumulator u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Fold one term into the shadow state and return the beat it should produce.
    // All arithmetic is done in 64-bit signed so divisions truncate toward zero
    // exactly as the block's integer math does.
    function automatic centroid_beat_t fold_term(input bit first, input point_t lp,
                                                 input point_t pp, input point_t rp,
                                                 input strength_t h);
        centroid_beat_t r;
        longint a, b, c, hl, mass, cen, diff, total, nv, v;
        a  = lp;
        b  = pp;
        c  = rp;
        hl = h;
        if (a > b || b > c)
        begin
            // out-of-order points: state untouched, first_term ignored
            r.rejected = 1'b1;
        end
        else
        begin
            if (first)
            begin
                shadow_value = '0;
                shadow_mass  = '0;
            end
            mass = (hl * (c - a)) / MASS_DIVISOR;
            cen  = (c + a) / 2 + (hl * (2 * b - c - a)) / SKEW_DIVISOR;
            v    = shadow_value;
            diff = cen - v;
            shadow_mass = shadow_mass + mass[31:0];
            // zero total mass leaves the value alone
            if (shadow_mass != 0)
            begin
                total = shadow_mass;
                nv    = v + (diff * mass) / total;
                if (nv > VALUE_MAX)
                    nv = VALUE_MAX;
                else if (nv < VALUE_MIN)
                    nv = VALUE_MIN;
                shadow_value = nv[16:0];
            end
            r.rejected = 1'b0;
        end
        v = shadow_value;
        if (v > CENTROID_MAX)
            v = CENTROID_MAX;
        else if (v < CENTROID_MIN)
            v = CENTROID_MIN;
        r.centroid   = v[15:0];
        r.total_mass = shadow_mass;
        return r;
    endfunction

    function automatic point_t rand_point();
        int v;
        case ($urandom_range(0, 5))
            0: v = -32768;
            1: v = 32767;
            2: v = int'($urandom_range(0, 64)) - 32;
            default: v = int'($urandom_range(0, 65535)) - 32768;
        endcase
        return point_t'(v);
    endfunction

    function automatic strength_t rand_strength();
        case ($urandom_range(0, 7))
            0: return strength_t'(0);
            1: return strength_t'(65536);
            2: return strength_t'($urandom_range(0, 255));
            3: return strength_t'(65535);
            default: return strength_t'($urandom_range(0, 65536));
        endcase
    endfunction

    // Send one term. Valid is left high after the accepting edge so a following
    // call can present the next beat in the same step without a dip.
    task automatic send_term(input bit first, input int lp, input int pp, input int rp,
                             input int h);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT)
            gap++;
        if (idle_on && $urandom_range(0, 99) < 8)
            gap += $urandom_range(1, 70);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 65){1'b0}}, strength_t'(h), point_t'(rp),
                     point_t'(pp), point_t'(lp)};
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_centroids.push_back(fold_term(first, point_t'(lp), point_t'(pp),
                                              point_t'(rp), strength_t'(h)));
    endtask

    // Stop sending and let every owed result come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_centroids.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_field_extremes();
        send_term(1'b1, -32768, 0, 32767, 65536);
        send_term(1'b0, -32768, -32768, -32768, 65536);
        send_term(1'b0, 32767, 32767, 32767, 0);
        send_term(1'b0, -32768, 32767, 32767, 65536);
        send_term(1'b0, -32768, -32768, 32767, 65535);
        send_term(1'b0, 0, 1, 2, 1);
    endtask

    task automatic test_rejected_terms();
        // first_term on a rejected beat must not clear anything
        send_term(1'b1, 1, 0, 2, 65536);
        send_term(1'b0, 0, 2, 1, 100);
        send_term(1'b1, 32767, -32768, -32768, 65536);
        send_term(1'b1, -32768, 32767, -32768, 0);
    endtask

    task automatic test_zero_mass();
        send_term(1'b1, 100, 200, 300, 0);
        send_term(1'b1, -5, -5, -5, 65536);
        send_term(1'b0, 10, 10, 10, 65536);
        send_term(1'b0, -1000, 0, 1000, 1000);
        // zero mass on top of a nonzero total
        send_term(1'b0, 7, 7, 7, 0);
    endtask

    task automatic test_accumulation();
        send_term(1'b1, -32768, -32768, -32767, 65536);
        send_term(1'b0, 20000, 30000, 32767, 65536);
        send_term(1'b0, -32768, -20000, -10000, 40000);
        send_term(1'b0, -3, 0, 3, 65536);
    endtask

    // Runs of terms: mostly a first_term beat followed by well-ordered terms,
    // with some noise beats (random order, random first flag) mixed in.
    task automatic test_random_runs(input int n_items);
        int   count, run_len, i;
        int   x, y, z, t;
        bit   first;
        count = 0;
        while (count < n_items)
        begin
            run_len = $urandom_range(1, 12);
            for (i = 0; i < run_len && count < n_items; i++)
            begin
                x = rand_point();
                y = rand_point();
                z = rand_point();
                if ($urandom_range(0, 99) < 85)
                begin
                    first = (i == 0);
                    if ($urandom_range(0, 19) == 0)
                    begin
                        y = x;
                        z = x;
                    end
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        // narrow triangle near x
                        y = x + int'($urandom_range(0, 200)) - 100;
                        z = x + int'($urandom_range(0, 200)) - 100;
                        if (y > 32767) y = 32767;
                        if (y < -32768) y = -32768;
                        if (z > 32767) z = 32767;
                        if (z < -32768) z = -32768;
                    end
                    if (x > y) begin t = x; x = y; y = t; end
                    if (y > z) begin t = y; y = z; z = t; end
                    if (x > y) begin t = x; x = y; y = t; end
                end
                else
                begin
                    first = $urandom_range(0, 1);
                end
                send_term(first, x, y, z, rand_strength());
                count++;
            end
        end
    endtask

    task automatic test_sender_pause();
        test_random_runs(6);
        wait_for_results();
        test_random_runs(6);
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        test_random_runs(350);
        wait_for_results();
        idle_on = 1'b1;
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_centroids.size() == 0)
                begin
                    $error("result beat with no term pending: tdata=%h tuser=%h",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    owed = pending_centroids.pop_front();
                    if (m_tdata[15:0] !== owed.centroid)
                    begin
                        $error("centroid: expected %0d, got %0d", owed.centroid,
                               point_t'(m_tdata[15:0]));
                        fail_count++;
                    end
                    if (m_tdata[47:16] !== owed.total_mass)
                    begin
                        $error("total_mass: expected %0d, got %0d", owed.total_mass,
                               m_tdata[47:16]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== owed.rejected)
                    begin
                        $error("term_rejected: expected %0d, got %0d", owed.rejected,
                               m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 199) == 0)
            begin
                stall_left = $urandom_range(5, 40);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // Hang detector: any beat on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        fail_count   = 0;
        quiet_cycles = 0;
        stall_left   = 0;
        idle_on      = 1'b1;
        shadow_value = '0;
        shadow_mass  = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_rejected_terms();
        test_zero_mass();
        test_accumulation();
        test_sender_pause();
        test_random_runs(800);
        test_back_to_back();
        test_random_runs(788);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
